// ----- hdl/itp_pkg.sv -----
// Shared types, character codes and decode functions for the infix-to-postfix converter.
// Used by infix_to_postfix_converter and itp_checker; depends on nothing else.
`default_nettype none

package itp_pkg;

   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NUL    = 8'h00;

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_SUB    = 3'd1,
      OP_MUL    = 3'd2,
      OP_DIV    = 3'd3,
      OP_POW    = 3'd4,
      OP_LPAREN = 3'd5
   } op_code_type;

   typedef enum logic [1:0] {
      KIND_CHAR    = 2'd0,
      KIND_END     = 2'd1,
      KIND_INVALID = 2'd2
   } rsp_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHK,
      ST_FIN,
      ST_MARK
   } state_type;

   typedef enum logic [1:0] {
      MODE_END,
      MODE_RPAREN,
      MODE_OP
   } mode_type;

   function automatic logic is_alnum(input logic [7:0] c);
      is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                 (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      is_space = (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   function automatic logic is_operator(input logic [7:0] c);
      is_operator = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
                    (c == CH_SLASH) || (c == CH_CARET);
   endfunction

   function automatic logic [2:0] char_to_op(input logic [7:0] c);
      unique case (c)
         CH_MINUS: char_to_op = OP_SUB;
         CH_STAR:  char_to_op = OP_MUL;
         CH_SLASH: char_to_op = OP_DIV;
         CH_CARET: char_to_op = OP_POW;
         default:  char_to_op = OP_ADD;
      endcase
   endfunction

   // Codes six and seven are never stored; they fold back as ADD and SUB.
   function automatic logic [7:0] op_to_char(input logic [2:0] code);
      unique case (code)
         OP_ADD:    op_to_char = CH_PLUS;
         OP_SUB:    op_to_char = CH_MINUS;
         OP_MUL:    op_to_char = CH_STAR;
         OP_DIV:    op_to_char = CH_SLASH;
         OP_POW:    op_to_char = CH_CARET;
         OP_LPAREN: op_to_char = CH_LPAREN;
         3'd6:      op_to_char = CH_PLUS;
         default:   op_to_char = CH_MINUS;
      endcase
   endfunction

   function automatic logic [1:0] op_prec(input logic [2:0] code);
      unique case (code)
         OP_MUL, OP_DIV: op_prec = 2'd2;
         OP_POW:         op_prec = 2'd3;
         OP_LPAREN:      op_prec = 2'd0;
         default:        op_prec = 2'd1;
      endcase
   endfunction

endpackage

`default_nettype wire

// ----- hdl/infix_to_postfix_converter.sv -----
// Streaming shunting-yard infix-to-postfix converter, top level.
// Depends on itp_pkg for operator codes, result kinds and character decode.
`default_nettype none

// Each req transaction carries one infix character (req_tuser = 0) or an end
// command (req_tuser = 1). Letters and digits leave at once as one rsp
// transaction; space, tab and unknown characters give nothing. Operators and
// '(' are kept on an operator stack of STACK_DEPTH entries held in a
// synchronous single-port-read memory with a registered read port; the
// stack pointer, the open-parenthesis count and a sticky error bit live in
// flip-flops. Whitespace, operands, unknown characters, '(', a ')' or an
// operator that finds the stack empty, and an end command on an invalid
// expression or an empty stack are handled without leaving the idle state.
// An operator or ')' that finds entries, or any other end command, holds off
// the next input while the stack is worked through, because every stack step
// waits for the memory read of the next lower entry. A low rsp_tready stalls
// these steps further. Every result sits in an output register, so a pending
// result never blocks acceptance of the next input if it is taken in the same
// cycle. rsp_tlast marks the last result caused by one input; an unmatched
// ')' or a push onto a full stack is recorded and reported as a single
// invalid-expression result at the end command.
module infix_to_postfix_converter #(
   parameter int STACK_DEPTH = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_char
   input  wire logic       req_tuser,   // [0] cmd
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_char
   output logic [1:0]      rsp_tuser,   // [1:0] kind
   output logic            rsp_tlast    // last
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   // Operator stack storage
   logic [2:0]       stack_mem [STACK_DEPTH];
   logic [2:0]       rd_data_ff;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [2:0]       wr_data;

   // Control state
   itp_pkg::state_type state_ff, state_in;
   itp_pkg::mode_type  mode_ff, mode_in;
   logic [2:0]         op_ff, op_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   open_ff, open_in;
   logic               err_ff, err_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [7:0]         pend_char_ff, pend_char_in;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_char_ff;
   logic [1:0]         rsp_kind_ff;
   logic               rsp_last_ff;
   logic               out_free;
   logic               emit_en;
   logic [7:0]         emit_char;
   logic [1:0]         emit_kind;
   logic               emit_last;

   logic [CNT_W-1:0]   top_idx;
   logic [CNT_W-1:0]   below_idx;
   logic               stack_full;
   logic               pops;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign top_idx    = count_ff - CNT_W'(1);
   assign below_idx  = count_ff - CNT_W'(2);
   assign stack_full = (count_ff == CNT_W'(STACK_DEPTH));
   assign wr_addr    = count_ff[IDX_W-1:0];

   // Decide whether the entry just read from the top leaves the stack.
   always_comb begin
      unique case (mode_ff)
         itp_pkg::MODE_END:    pops = 1'b1;
         itp_pkg::MODE_RPAREN: pops = (rd_data_ff != 3'(itp_pkg::OP_LPAREN));
         default:              pops = (itp_pkg::op_prec(rd_data_ff) >=
                                       itp_pkg::op_prec(op_ff));
      endcase
   end

   // Sequencer: next state, stack access and result generation
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      op_in         = op_ff;
      count_in      = count_ff;
      open_in       = open_ff;
      err_in        = err_ff;
      pend_valid_in = pend_valid_ff;
      pend_char_in  = pend_char_ff;
      req_tready    = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = top_idx[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_data       = op_ff;
      emit_en       = 1'b0;
      emit_char     = itp_pkg::CH_NUL;
      emit_kind     = 2'(itp_pkg::KIND_CHAR);
      emit_last     = 1'b0;

      unique case (state_ff)
         itp_pkg::ST_IDLE: begin
            req_tready = out_free;
            if (req_tvalid && out_free) begin
               if (req_tuser) begin
                  if (open_ff != '0 || err_ff) begin
                     emit_en   = 1'b1;
                     emit_kind = 2'(itp_pkg::KIND_INVALID);
                     emit_last = 1'b1;
                     count_in  = '0;
                     open_in   = '0;
                     err_in    = 1'b0;
                  end else if (count_ff == '0) begin
                     emit_en   = 1'b1;
                     emit_kind = 2'(itp_pkg::KIND_END);
                     emit_last = 1'b1;
                  end else begin
                     mode_in  = itp_pkg::MODE_END;
                     rd_en    = 1'b1;
                     state_in = itp_pkg::ST_CHK;
                  end
               end else begin
                  priority if (itp_pkg::is_space(req_tdata)) begin
                     // skip whitespace
                  end else if (itp_pkg::is_alnum(req_tdata)) begin
                     emit_en   = 1'b1;
                     emit_char = req_tdata;
                     emit_last = 1'b1;
                  end else if (req_tdata == itp_pkg::CH_LPAREN) begin
                     if (stack_full) begin
                        err_in = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        wr_data  = 3'(itp_pkg::OP_LPAREN);
                        count_in = count_ff + CNT_W'(1);
                        open_in  = open_ff + CNT_W'(1);
                     end
                  end else if (req_tdata == itp_pkg::CH_RPAREN) begin
                     if (count_ff == '0) begin
                        err_in = 1'b1;
                     end else begin
                        mode_in  = itp_pkg::MODE_RPAREN;
                        rd_en    = 1'b1;
                        state_in = itp_pkg::ST_CHK;
                     end
                  end else if (itp_pkg::is_operator(req_tdata)) begin
                     op_in = itp_pkg::char_to_op(req_tdata);
                     if (count_ff == '0) begin
                        wr_en    = 1'b1;
                        wr_data  = itp_pkg::char_to_op(req_tdata);
                        count_in = CNT_W'(1);
                     end else begin
                        mode_in  = itp_pkg::MODE_OP;
                        rd_en    = 1'b1;
                        state_in = itp_pkg::ST_CHK;
                     end
                  end else begin
                     // drop unknown characters
                  end
               end
            end
         end

         itp_pkg::ST_CHK: begin
            if (out_free) begin
               if (pops) begin
                  count_in = top_idx;
                  if (mode_ff == itp_pkg::MODE_END) begin
                     // flush: emit straight away, the end marker follows
                     emit_en   = 1'b1;
                     emit_char = itp_pkg::op_to_char(rd_data_ff);
                  end else begin
                     // hold the popped operator until we know if it is the last
                     emit_en       = pend_valid_ff;
                     emit_char     = pend_char_ff;
                     pend_valid_in = 1'b1;
                     pend_char_in  = itp_pkg::op_to_char(rd_data_ff);
                  end
                  if (count_ff == CNT_W'(1)) begin
                     if (mode_ff == itp_pkg::MODE_END) begin
                        state_in = itp_pkg::ST_MARK;
                     end else begin
                        if (mode_ff == itp_pkg::MODE_RPAREN) begin
                           err_in = 1'b1;
                        end
                        state_in = itp_pkg::ST_FIN;
                     end
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = below_idx[IDX_W-1:0];
                  end
               end else begin
                  if (mode_ff == itp_pkg::MODE_RPAREN) begin
                     count_in = top_idx;
                     open_in  = open_ff - CNT_W'(1);
                  end
                  state_in = itp_pkg::ST_FIN;
               end
            end
         end

         itp_pkg::ST_FIN: begin
            if (!pend_valid_ff || out_free) begin
               if (mode_ff == itp_pkg::MODE_OP) begin
                  if (stack_full) begin
                     err_in = 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               emit_en       = pend_valid_ff;
               emit_char     = pend_char_ff;
               emit_last     = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = itp_pkg::ST_IDLE;
            end
         end

         itp_pkg::ST_MARK: begin
            if (out_free) begin
               emit_en   = 1'b1;
               emit_kind = 2'(itp_pkg::KIND_END);
               emit_last = 1'b1;
               count_in  = '0;
               open_in   = '0;
               err_in    = 1'b0;
               state_in  = itp_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = itp_pkg::ST_IDLE;
         end
      endcase
   end

   // Advance the output register: load on emit, drop when taken
   always_comb begin
      if (emit_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Stack memory: writes and reads never target one entry in the same cycle,
   // since pushes happen only outside the pop loop.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= itp_pkg::ST_IDLE;
         count_ff      <= '0;
         open_ff       <= '0;
         err_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         open_ff       <= open_in;
         err_ff        <= err_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      op_ff        <= op_in;
      pend_char_ff <= pend_char_in;
      if (emit_en) begin
         rsp_char_ff <= emit_char;
         rsp_kind_ff <= emit_kind;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ----- hdl/itp_checker.sv -----
// Port-level checks for infix_to_postfix_converter, attached by bind.
// Depends on itp_pkg for character codes and result kinds.
`default_nettype none

module itp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic [7:0] req_tdata,
   input wire logic       req_tuser,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic [1:0] rsp_tuser,
   input wire logic       rsp_tlast
);

   // A stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // End and invalid markers carry no character and close their transaction group
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == 2'(itp_pkg::KIND_END) ||
                     rsp_tuser == 2'(itp_pkg::KIND_INVALID))
      |-> rsp_tlast && rsp_tdata == itp_pkg::CH_NUL)
      else $error("marker result with data or without tlast");

   // Postfix characters are never zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == 2'(itp_pkg::KIND_CHAR) |-> rsp_tdata != itp_pkg::CH_NUL)
      else $error("postfix character result is zero");

   // Whitespace leaves the block ready in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser && itp_pkg::is_space(req_tdata)
      |=> req_tready)
      else $error("not ready after whitespace");

   // An operand comes out alone in the next cycle, unchanged
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser && itp_pkg::is_alnum(req_tdata)
      |=> rsp_tvalid && rsp_tlast && rsp_tdata == $past(req_tdata) &&
          rsp_tuser == 2'(itp_pkg::KIND_CHAR))
      else $error("operand not passed through");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (.*);

`default_nettype wire
